FILE: rtl/ssp_pkg.sv
// Shared widths and controller/datapath interface types for the selection sorter.
package ssp_pkg;

    localparam int KEY_W  = 32;
    localparam int ID_W   = 32;
    localparam int PAIR_W = KEY_W + ID_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // store the accepted input pair if there is room
        logic clr_idx;     // zero the start position and output index
        logic rd_start;    // read the entry at the start position
        logic rd_next;     // read the entry after the scan pointer
        logic take_first;  // seed best and start pair from the read data
        logic take_cmp;    // compare read data against best
        logic wr_best;     // write best pair at the start position
        logic wr_start;    // write start pair at the best position
        logic adv_start;   // advance the start position
        logic rd_out;      // read the entry at the output index
        logic out_load;    // load the output register from the read data
        logic out_done;    // output item taken
        logic out_next;    // advance the output index and read it
        logic clr_count;   // empty the store
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_small;     // fewer than two pairs stored
        logic scan_more;   // entries remain after the scan pointer
        logic start_more;  // another start position remains after this one
        logic out_last;    // output register holds the final pair
    } status_t;

endpackage

FILE: rtl/ssp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/ssp_datapath.sv
// Datapath: pair store, scan pointers, best-key tracking and output register.
module ssp_datapath
    import ssp_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cmd_t                    cmd,
    input  logic signed [KEY_W-1:0] in_key,
    input  logic signed [ID_W-1:0]  in_id,
    output status_t                 status,
    output logic signed [KEY_W-1:0] out_key,
    output logic signed [ID_W-1:0]  out_id,
    output logic                    out_last,
    output logic                    out_valid
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    logic [CW-1:0]           count_reg, start_reg, ptr_reg, k_reg;
    logic signed [KEY_W-1:0] best_key_reg, start_key_reg, out_key_reg;
    logic signed [ID_W-1:0]  best_id_reg, start_id_reg, out_id_reg;
    logic [AW-1:0]           best_idx_reg;
    logic                    out_last_reg, out_valid_reg;

    logic                    wr_en, rd_en, has_room;
    logic [AW-1:0]           wr_addr, rd_addr;
    logic [PAIR_W-1:0]       wr_data, rd_data;
    logic signed [KEY_W-1:0] rd_key;
    logic signed [ID_W-1:0]  rd_id;

    assign has_room = (count_reg < DEPTH_C);
    assign rd_key   = signed'(rd_data[KEY_W-1:0]);
    assign rd_id    = signed'(rd_data[PAIR_W-1:KEY_W]);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = {in_id, in_key};
        if (cmd.load && has_room) begin
            wr_en = 1'b1;
        end
        if (cmd.wr_best) begin
            wr_en   = 1'b1;
            wr_addr = start_reg[AW-1:0];
            wr_data = {best_id_reg, best_key_reg};
        end
        if (cmd.wr_start) begin
            wr_en   = 1'b1;
            wr_addr = best_idx_reg;
            wr_data = {start_id_reg, start_key_reg};
        end
    end

    always_comb begin
        rd_en   = cmd.rd_start | cmd.rd_next | cmd.rd_out | cmd.out_next;
        rd_addr = start_reg[AW-1:0];
        if (cmd.rd_next) begin
            rd_addr = ptr_reg[AW-1:0] + AW'(1);
        end
        if (cmd.rd_out) begin
            rd_addr = k_reg[AW-1:0];
        end
        if (cmd.out_next) begin
            rd_addr = k_reg[AW-1:0] + AW'(1);
        end
    end

    ssp_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            start_reg     <= '0;
            ptr_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load && has_room) begin
                count_reg <= count_reg + ONE_C;
            end
            if (cmd.clr_count) begin
                count_reg <= '0;
            end
            if (cmd.clr_idx) begin
                start_reg <= '0;
                k_reg     <= '0;
            end
            if (cmd.rd_start) begin
                ptr_reg <= start_reg;
            end
            if (cmd.rd_next) begin
                ptr_reg <= ptr_reg + ONE_C;
            end
            if (cmd.adv_start) begin
                start_reg <= start_reg + ONE_C;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end
            if (cmd.out_done) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.out_next) begin
                k_reg <= k_reg + ONE_C;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take_first) begin
            best_key_reg  <= rd_key;
            best_id_reg   <= rd_id;
            best_idx_reg  <= ptr_reg[AW-1:0];
            start_key_reg <= rd_key;
            start_id_reg  <= rd_id;
        end
        // strict compare keeps the first index of equal keys
        if (cmd.take_cmp && (rd_key > best_key_reg)) begin
            best_key_reg <= rd_key;
            best_id_reg  <= rd_id;
            best_idx_reg <= ptr_reg[AW-1:0];
        end
        if (cmd.out_load) begin
            out_key_reg  <= rd_key;
            out_id_reg   <= rd_id;
            out_last_reg <= ((k_reg + ONE_C) == count_reg);
        end
    end

    assign status.n_small    = (count_reg < TWO_C);
    assign status.scan_more  = ((ptr_reg + ONE_C) < count_reg);
    assign status.start_more = ((start_reg + TWO_C) < count_reg);
    assign status.out_last   = out_last_reg;

    assign out_key   = out_key_reg;
    assign out_id    = out_id_reg;
    assign out_last  = out_last_reg;
    assign out_valid = out_valid_reg;

endmodule

FILE: rtl/ssp_ctrl.sv
// Controller: load, selection passes with swap, and ordered readout.
module ssp_ctrl
    import ssp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  logic    in_last,
    output logic    in_ready,
    input  logic    out_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [9:0] {
        S_LOAD     = 10'b00_0000_0001,
        S_CHECK    = 10'b00_0000_0010,
        S_SCAN_RD  = 10'b00_0000_0100,
        S_SCAN_HD  = 10'b00_0000_1000,
        S_SCAN     = 10'b00_0001_0000,
        S_SWAP_A   = 10'b00_0010_0000,
        S_SWAP_B   = 10'b00_0100_0000,
        S_OUT_RD   = 10'b00_1000_0000,
        S_OUT_LD   = 10'b01_0000_0000,
        S_OUT_HOLD = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load = 1'b1;
                    if (in_last) begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                cmd.clr_idx = 1'b1;
                state_next  = status.n_small ? S_OUT_RD : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                cmd.rd_start = 1'b1;
                state_next   = S_SCAN_HD;
            end
            S_SCAN_HD: begin
                cmd.take_first = 1'b1;
                cmd.rd_next    = 1'b1;
                state_next     = S_SCAN;
            end
            S_SCAN: begin
                cmd.take_cmp = 1'b1;
                if (status.scan_more) begin
                    cmd.rd_next = 1'b1;
                end else begin
                    state_next = S_SWAP_A;
                end
            end
            S_SWAP_A: begin
                cmd.wr_best = 1'b1;
                state_next  = S_SWAP_B;
            end
            S_SWAP_B: begin
                cmd.wr_start = 1'b1;
                if (status.start_more) begin
                    cmd.adv_start = 1'b1;
                    state_next    = S_SCAN_RD;
                end else begin
                    state_next = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                cmd.rd_out = 1'b1;
                state_next = S_OUT_LD;
            end
            S_OUT_LD: begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (out_ready) begin
                    cmd.out_done = 1'b1;
                    if (status.out_last) begin
                        cmd.clr_count = 1'b1;
                        state_next    = S_LOAD;
                    end else begin
                        cmd.out_next = 1'b1;
                        state_next   = S_OUT_LD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/selection_sort_with_payload_top.sv
// Top level of the descending selection sorter with payload.
//
// Usage:
//   Input stream (s_): each item carries a signed 32-bit key and a signed
//   32-bit payload id in s_tdata; s_tlast marks the final item of a set.
//   Up to DEPTH items are stored; further items are dropped, but an item
//   with s_tlast still closes the set.
//   Output stream (m_): after the sort, every stored pair leaves in
//   descending key order, the id traveling with its key; m_tlast flags
//   the final pair. Equal keys are not always kept in arrival order.
// Flow:
//   Loading takes one cycle per item. The sort uses one comparator and one
//   read port of the pair store, one entry per cycle: each pass scans from
//   its start position to the last entry for the largest key, then swaps it
//   into the start position. Readout holds each pair until it is taken.
//   s_tready is high only while loading; a new set is accepted in the cycle
//   after the final pair is taken.
// Reset: synchronous, active-low aresetn empties the store and returns to
//   loading. Store contents are not cleared.
// Stall: a low m_tready holds the current pair on m_tdata/m_tlast.
module selection_sort_with_payload_top
    import ssp_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] sort_key, [63:32] payload_id
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] sorted_key, [63:32] sorted_id
    output logic        m_tlast    // end_of_run
);

    cmd_t                    cmd;
    status_t                 status;
    logic signed [KEY_W-1:0] out_key;
    logic signed [ID_W-1:0]  out_id;

    // Sequence load, sort passes and readout.
    ssp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the pairs and do the compares and swaps.
    ssp_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_key    (signed'(s_tdata[KEY_W-1:0])),
        .in_id     (signed'(s_tdata[PAIR_W-1:KEY_W])),
        .status    (status),
        .out_key   (out_key),
        .out_id    (out_id),
        .out_last  (m_tlast),
        .out_valid (m_tvalid)
    );

    assign m_tdata = {out_id, out_key};

    // Loading and readout never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while an output item is pending");

    // Closing a set stops loading until readout ends.
    a_close_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("still loading after the final input item");

    // Taking the final output item reopens the input.
    a_reopen: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("input not reopened after the final output item");

endmodule
